[sv/nplk_pkg.sv]
// ----------------------------------------------------------------------------
// nplk_pkg
// Shared widths, codes and controller/datapath handshake types for the
// nearest point label lookup core.
// ----------------------------------------------------------------------------
`default_nettype none

package nplk_pkg;

  localparam int SLOT_W  = 10;
  localparam int LABEL_W = 24;
  localparam int DIST_W  = 50;
  localparam int COUNT_W = 11;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [COUNT_W-1:0] REF_COUNT_RESET = COUNT_W'(1);

  typedef struct packed {
    logic q_load;
    logic wr_en;
    logic scan_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic done;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

[sv/nplk_ram.sv]
// ----------------------------------------------------------------------------
// nplk_ram
// Generic simple dual port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module nplk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/nplk_ctrl.sv]
// ----------------------------------------------------------------------------
// nplk_ctrl
// Controller: accepts load and query beats, sequences the reference scan,
// waits for the pipeline to drain and hands the result to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module nplk_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_action_i,
  output logic                   in_ready_o,
  input  wire nplk_pkg::status_t status_i,
  output nplk_pkg::cmd_t         cmd_o
);

  import nplk_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    cmd_o.wr_en     = accept & (in_action_i == ACT_LOAD);
    cmd_o.q_load    = accept & (in_action_i == ACT_QUERY);
    cmd_o.scan_step = (state_q == ST_SCAN);
    cmd_o.out_load  = (state_q == ST_FINISH) & status_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.q_load) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[sv/nplk_dpath.sv]
// ----------------------------------------------------------------------------
// nplk_dpath
// Datapath: reference point store, scan counter, distance pipeline
// (read, difference, square, sum, compare) and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nplk_dpath #(
  parameter int MAX_REFS   = 1024,
  parameter int COORD_BITS = 24,
  localparam int AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire nplk_pkg::cmd_t               cmd_i,
  output nplk_pkg::status_t                 status_o,
  input  wire logic [AW-1:0]                last_idx_i,
  input  wire logic [nplk_pkg::SLOT_W-1:0]  slot_i,
  input  wire logic signed [COORD_BITS-1:0] coord_x_i,
  input  wire logic signed [COORD_BITS-1:0] coord_y_i,
  input  wire logic signed [COORD_BITS-1:0] coord_z_i,
  input  wire logic [nplk_pkg::LABEL_W-1:0] point_label_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [nplk_pkg::LABEL_W-1:0]      nearest_label_o,
  output logic [nplk_pkg::SLOT_W-1:0]       nearest_slot_o,
  output logic [nplk_pkg::DIST_W-1:0]       min_dist_sq_o
);

  import nplk_pkg::*;

  localparam int DF_W  = COORD_BITS + 1;
  localparam int SQ_W  = 2 * COORD_BITS + 1;
  localparam int SUM_W = SQ_W + 2;
  localparam int MW    = 3 * COORD_BITS + LABEL_W;
  localparam int SW    = (AW + 1 > SLOT_W) ? AW + 1 : SLOT_W;

  logic signed [COORD_BITS-1:0] qx_q, qy_q, qz_q;
  logic [AW-1:0]                idx_q;
  logic                         slot_ok;
  logic [MW-1:0]                rdata;
  logic signed [COORD_BITS-1:0] rx, ry, rz;
  logic [LABEL_W-1:0]           rlabel;

  logic                         a_vld_q, a_first_q, a_last_q;
  logic [AW-1:0]                a_slot_q;
  logic                         b_vld_q, b_first_q, b_last_q;
  logic [AW-1:0]                b_slot_q;
  logic [LABEL_W-1:0]           b_label_q;
  logic signed [DF_W-1:0]       b_dx_q, b_dy_q, b_dz_q;
  logic                         c_vld_q, c_first_q, c_last_q;
  logic [AW-1:0]                c_slot_q;
  logic [LABEL_W-1:0]           c_label_q;
  logic [SQ_W-1:0]              c_sx_q, c_sy_q, c_sz_q;
  logic                         d_vld_q, d_first_q, d_last_q;
  logic [AW-1:0]                d_slot_q;
  logic [LABEL_W-1:0]           d_label_q;
  logic [SUM_W-1:0]             d_sum_q;

  logic [SUM_W-1:0]             best_dist_q;
  logic [AW-1:0]                best_slot_q;
  logic [LABEL_W-1:0]           best_label_q;
  logic                         take;
  logic                         out_vld_q;
  logic signed [2*DF_W-1:0]     px, py, pz;

  assign slot_ok = (SW'(slot_i) < SW'(MAX_REFS));

  nplk_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_REFS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en & slot_ok),
    .waddr_i (AW'(slot_i)),
    .wdata_i ({point_label_i, coord_z_i, coord_y_i, coord_x_i}),
    .re_i    (cmd_i.scan_step),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  assign rx     = rdata[COORD_BITS-1:0];
  assign ry     = rdata[2*COORD_BITS-1:COORD_BITS];
  assign rz     = rdata[3*COORD_BITS-1:2*COORD_BITS];
  assign rlabel = rdata[MW-1:3*COORD_BITS];

  always_comb begin
    status_o.scan_last = cmd_i.scan_step & (idx_q == last_idx_i);
    status_o.done      = d_vld_q & d_last_q;
    status_o.out_free  = ~out_vld_q | out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_load) begin
      qx_q <= coord_x_i;
      qy_q <= coord_y_i;
      qz_q <= coord_z_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      if (cmd_i.q_load) begin
        idx_q <= '0;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + AW'(1);
      end
      a_vld_q <= cmd_i.scan_step;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  assign px = b_dx_q * b_dx_q;
  assign py = b_dy_q * b_dy_q;
  assign pz = b_dz_q * b_dz_q;

  always_ff @(posedge clk_i) begin
    a_first_q <= (idx_q == '0);
    a_last_q  <= status_o.scan_last;
    a_slot_q  <= idx_q;

    b_first_q <= a_first_q;
    b_last_q  <= a_last_q;
    b_slot_q  <= a_slot_q;
    b_label_q <= rlabel;
    b_dx_q    <= DF_W'(rx) - DF_W'(qx_q);
    b_dy_q    <= DF_W'(ry) - DF_W'(qy_q);
    b_dz_q    <= DF_W'(rz) - DF_W'(qz_q);

    c_first_q <= b_first_q;
    c_last_q  <= b_last_q;
    c_slot_q  <= b_slot_q;
    c_label_q <= b_label_q;
    c_sx_q    <= px[SQ_W-1:0];
    c_sy_q    <= py[SQ_W-1:0];
    c_sz_q    <= pz[SQ_W-1:0];

    d_first_q <= c_first_q;
    d_last_q  <= c_last_q;
    d_slot_q  <= c_slot_q;
    d_label_q <= c_label_q;
    d_sum_q   <= SUM_W'(c_sx_q) + SUM_W'(c_sy_q) + SUM_W'(c_sz_q);
  end

  assign take = d_vld_q & (d_first_q | (d_sum_q < best_dist_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_dist_q  <= d_sum_q;
      best_slot_q  <= d_slot_q;
      best_label_q <= d_label_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      nearest_label_o <= best_label_q;
      nearest_slot_o  <= SLOT_W'(best_slot_q);
      min_dist_sq_o   <= DIST_W'(best_dist_q);
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

[sv/nearest_point_label_lookup_core.sv]
// ----------------------------------------------------------------------------
// nearest_point_label_lookup_core
// Brute-force 3D nearest neighbor search over a store of labeled reference
// points, returning label, slot and squared distance of the nearest one.
//
//   channel   direction  beat carries
//   s_axis    in         tuser: action; tdata: slot, coord_x/y/z, point_label
//   m_axis    out        tdata: nearest_label, nearest_slot, min_dist_sq
//   apb       in/out     ref_count at byte address 0
//
// A load beat writes the point to the store on accept. A query scans the
// first ref_count stored points, one per cycle, through the single read port
// of the store, then the distance pipeline (read, difference, square, sum,
// compare) drains. Reset clears control state only; the store is not cleared.
// Results sit in an output register, so loads are accepted while a result
// waits; a further query stalls at its end until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_point_label_lookup_core #(
  parameter int MAX_REFS   = 1024,
  parameter int COORD_BITS = 24,
  localparam int IN_W  = ((nplk_pkg::SLOT_W + 3 * COORD_BITS + nplk_pkg::LABEL_W + 7) / 8) * 8,
  localparam int OUT_W = ((nplk_pkg::LABEL_W + nplk_pkg::SLOT_W + nplk_pkg::DIST_W + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: slot, coord_x, coord_y, coord_z, point_label, zero pad
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  // tuser: action
  input  wire logic             s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // tdata: nearest_label, nearest_slot, min_dist_sq, zero pad
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  import nplk_pkg::*;

  localparam int AW = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
  localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
  localparam int X_LO = SLOT_W;
  localparam int Y_LO = X_LO + COORD_BITS;
  localparam int Z_LO = Y_LO + COORD_BITS;
  localparam int L_LO = Z_LO + COORD_BITS;

  logic [COUNT_W-1:0]   ref_count_q;
  logic                 reg_sel;
  logic [CW-1:0]        count_ext, n_eff;
  logic [AW-1:0]        last_idx;
  cmd_t                 cmd;
  status_t              status;
  logic [LABEL_W-1:0]   nearest_label;
  logic [SLOT_W-1:0]    nearest_slot;
  logic [DIST_W-1:0]    min_dist_sq;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign prdata  = reg_sel ? 32'(ref_count_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_count_q <= REF_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      ref_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  assign count_ext = CW'(ref_count_q);
  assign n_eff = (count_ext == '0) ? CW'(1) :
                 (count_ext > CW'(MAX_REFS)) ? CW'(MAX_REFS) : count_ext;
  assign last_idx = AW'(n_eff - CW'(1));

  nplk_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  nplk_dpath #(
    .MAX_REFS   (MAX_REFS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .last_idx_i      (last_idx),
    .slot_i          (s_axis_tdata[SLOT_W-1:0]),
    .coord_x_i       (s_axis_tdata[Y_LO-1:X_LO]),
    .coord_y_i       (s_axis_tdata[Z_LO-1:Y_LO]),
    .coord_z_i       (s_axis_tdata[L_LO-1:Z_LO]),
    .point_label_i   (s_axis_tdata[L_LO+LABEL_W-1:L_LO]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .nearest_label_o (nearest_label),
    .nearest_slot_o  (nearest_slot),
    .min_dist_sq_o   (min_dist_sq)
  );

  assign m_axis_tdata = OUT_W'({min_dist_sq, nearest_slot, nearest_label});

  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.done |-> !s_axis_tready)
    else $error("scan pipeline finished while controller idle");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over an untaken result");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (CW'(nearest_slot) < n_eff))
    else $error("nearest slot beyond searched range");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_step |-> !cmd.wr_en)
    else $error("store written during scan");

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest point label lookup core. Reference
// points are loaded over the input stream and queries are checked against a
// scan of a local copy of the point store, with the searched slot count set
// over APB while the input is idle. A directed table covers field extremes, count
// clamping and ties, then random traffic runs under changing back pressure.
// ----------------------------------------------------------------------------
module tb;
  import nplk_pkg::*;

  localparam int N_SLOTS = 1024;
  localparam int FILL_N  = 256;
  localparam logic signed [23:0] C_MIN = 24'sh800000;
  localparam logic signed [23:0] C_MAX = 24'sh7FFFFF;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_QUERY} row_kind_e;

  typedef struct packed {
    logic [DIST_W-1:0]  dsq;
    logic [SLOT_W-1:0]  slot;
    logic [LABEL_W-1:0] label;
  } hit_t;

  typedef struct {
    row_kind_e          kind;
    logic [31:0]        cfg;
    logic [SLOT_W-1:0]  slot;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [LABEL_W-1:0] label;
    bit                 fixed;
    hit_t               want;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  logic signed [23:0] pt_x [N_SLOTS];
  logic signed [23:0] pt_y [N_SLOTS];
  logic signed [23:0] pt_z [N_SLOTS];
  logic [LABEL_W-1:0] pt_label [N_SLOTS];
  logic [COUNT_W-1:0] ref_cnt = REF_COUNT_RESET;
  int                 scan_n = 1;

  hit_t pending_hits [$];
  row_t dir_tab [$];
  int   errors = 0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;

  nearest_point_label_lookup_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #40000000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic hit_t nearest_ref(logic signed [23:0] qx, logic signed [23:0] qy,
                                       logic signed [23:0] qz);
    hit_t   h;
    longint dx, dy, dz, d, best_d;
    int     best;
    best = 0;
    best_d = 0;
    for (int i = 0; i < scan_n; i++) begin
      dx = longint'(pt_x[i]) - longint'(qx);
      dy = longint'(pt_y[i]) - longint'(qy);
      dz = longint'(pt_z[i]) - longint'(qz);
      d = dx * dx + dy * dy + dz * dz;
      if (i == 0 || d < best_d) begin
        best_d = d;
        best = i;
      end
    end
    h.label = pt_label[best];
    h.slot = SLOT_W'(best);
    h.dsq = DIST_W'(best_d);
    return h;
  endfunction

  function automatic logic signed [23:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return C_MIN;
      1: return C_MAX;
      2, 3, 4: return 24'(int'($urandom_range(0, 8)) - 4);
      5, 6: return 24'(int'($urandom_range(0, 4000)) - 2000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic row_t mk_row(row_kind_e kind, logic [31:0] cfg, logic [SLOT_W-1:0] sl,
                                  logic signed [23:0] x, logic signed [23:0] y,
                                  logic signed [23:0] z, logic [LABEL_W-1:0] lb, bit fixed,
                                  logic [LABEL_W-1:0] w_label, logic [SLOT_W-1:0] w_slot,
                                  logic [63:0] w_dist);
    row_t r;
    r.kind = kind;
    r.cfg = cfg;
    r.slot = sl;
    r.x = x;
    r.y = y;
    r.z = z;
    r.label = lb;
    r.fixed = fixed;
    r.want.label = w_label;
    r.want.slot = w_slot;
    r.want.dsq = DIST_W'(w_dist);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("tb: mismatch on %s: got 0x%0h, want 0x%0h", what, got, want);
    errors++;
  endtask

  // drop valid, wait for all results, then let the core settle
  task automatic hold_off(int extra);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_ref_count(logic [31:0] v);
    hold_off(16);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = '0;
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    ref_cnt = v[COUNT_W-1:0];
    scan_n = (ref_cnt == 0) ? 1 : ((ref_cnt > N_SLOTS) ? N_SLOTS : int'(ref_cnt));
  endtask

  task automatic send_beat(logic act, logic [SLOT_W-1:0] sl, logic signed [23:0] x,
                           logic signed [23:0] y, logic signed [23:0] z,
                           logic [LABEL_W-1:0] lb, bit fixed, hit_t want);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = act;
    s_axis_tdata = {6'b0, lb, z, y, x, sl};
    do @(posedge clk_i); while (!s_axis_tready);
    if (act == ACT_LOAD) begin
      pt_x[sl] = x;
      pt_y[sl] = y;
      pt_z[sl] = z;
      pt_label[sl] = lb;
    end else begin
      pending_hits.push_back(fixed ? want : nearest_ref(x, y, z));
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    hit_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("unexpected beat", longint'(m_axis_tdata[83:0]), 0);
      end else begin
        want = pending_hits.pop_front();
        if (m_axis_tdata[23:0] !== want.label)
          report_mismatch("nearest_label", longint'(m_axis_tdata[23:0]), longint'(want.label));
        if (m_axis_tdata[33:24] !== want.slot)
          report_mismatch("nearest_slot", longint'(m_axis_tdata[33:24]), longint'(want.slot));
        if (m_axis_tdata[83:34] !== want.dsq)
          report_mismatch("min_dist_sq", longint'(m_axis_tdata[83:34]), longint'(want.dsq));
      end
    end
  end

  initial begin
    hit_t               none;
    logic               act;
    logic [SLOT_W-1:0]  sl;
    logic signed [23:0] x, y, z;
    logic [31:0]        cv;
    int                 left, seg, src;
    none = '0;
    tx_idle_pct = 10;
    rx_idle_pct = 50;

    dir_tab.push_back(mk_row(ROW_LOAD, 0, 10'd0, C_MIN, C_MIN, C_MIN, 24'hFFFFFF, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(ROW_QUERY, 0, 10'd0, C_MAX, C_MAX, C_MAX, 24'd0, 1,
                             24'hFFFFFF, 10'd0, 64'd844424829468675));
    dir_tab.push_back(mk_row(ROW_QUERY, 0, 10'h3FF, C_MIN, C_MIN, C_MIN, 24'hFFFFFF, 1,
                             24'hFFFFFF, 10'd0, 64'd0));
    dir_tab.push_back(mk_row(ROW_LOAD, 0, 10'd1, 24'sd0, 24'sd0, 24'sd0, 24'd0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(ROW_LOAD, 0, 10'h3FF, C_MAX, C_MAX, C_MAX, 24'h123456, 0,
                             0, 0, 0));
    dir_tab.push_back(mk_row(ROW_CFG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(ROW_QUERY, 0, 10'd0, 24'sd0, 24'sd0, 24'sd0, 24'd0, 1,
                             24'hFFFFFF, 10'd0, 64'd211106232532992));
    dir_tab.push_back(mk_row(ROW_CFG, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(ROW_QUERY, 0, 10'd0, 24'sd0, 24'sd0, 24'sd0, 24'd0, 1,
                             24'd0, 10'd1, 64'd0));
    dir_tab.push_back(mk_row(ROW_LOAD, 0, 10'd2, 24'sd0, 24'sd0, 24'sd0, 24'hABCDEF, 0,
                             0, 0, 0));
    dir_tab.push_back(mk_row(ROW_CFG, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(ROW_QUERY, 0, 10'd0, 24'sd0, 24'sd0, 24'sd0, 24'd0, 1,
                             24'd0, 10'd1, 64'd0));
    dir_tab.push_back(mk_row(ROW_LOAD, 0, 10'd3, 24'sd1, -24'sd1, 24'sd1, 24'd5, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(ROW_CFG, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(ROW_QUERY, 0, 10'd0, 24'sd1, -24'sd1, 24'sd1, 24'd0, 1,
                             24'd5, 10'd3, 64'd0));
    dir_tab.push_back(mk_row(ROW_QUERY, 0, 10'd0, 24'sd2, -24'sd1, 24'sd1, 24'd0, 0, 0, 0, 0));
    dir_tab.push_back(mk_row(ROW_QUERY, 0, 10'h155, C_MAX, 24'sd0, 24'sd0, 24'hAAAAAA, 0,
                             0, 0, 0));
    dir_tab.push_back(mk_row(ROW_QUERY, 0, 10'h3FF, -24'sd5, 24'sd7, -24'sd9, 24'hFFFFFF, 0,
                             0, 0, 0));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        set_ref_count(dir_tab[i].cfg);
      end else begin
        send_beat((dir_tab[i].kind == ROW_QUERY) ? ACT_QUERY : ACT_LOAD, dir_tab[i].slot,
                  dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].label,
                  dir_tab[i].fixed, dir_tab[i].want);
      end
    end

    // fill the low slots so any count up to FILL_N may be searched
    for (int i = 0; i < FILL_N; i++) begin
      send_beat(ACT_LOAD, SLOT_W'(i), pick_coord(), pick_coord(), pick_coord(),
                24'($urandom), 0, none);
    end
    set_ref_count(32'(FILL_N));
    send_beat(ACT_QUERY, 10'd0, C_MIN, C_MAX, C_MIN, 24'd0, 0, none);
    send_beat(ACT_QUERY, 10'd0, pick_coord(), pick_coord(), pick_coord(), 24'd0, 0, none);
    set_ref_count(32'(FILL_N - 1));
    send_beat(ACT_QUERY, 10'd0, 24'sd0, 24'sd0, 24'sd0, 24'd0, 0, none);
    set_ref_count(32'd0);
    send_beat(ACT_QUERY, 10'd0, C_MAX, C_MIN, C_MAX, 24'd0, 0, none);

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 10 : ((ph == 1) ? 50 : 0);
      rx_idle_pct = (ph == 0) ? 50 : ((ph == 1) ? 10 : 0);
      left = 100;
      while (left > 0) begin
        case ($urandom_range(0, 9))
          0: cv = 32'($urandom_range(17, FILL_N));
          1: begin
            case ($urandom_range(0, 1))
              0: cv = 32'd0;
              default: cv = 32'(FILL_N);
            endcase
          end
          default: cv = 32'($urandom_range(1, 16));
        endcase
        set_ref_count(cv);
        seg = $urandom_range(20, 50);
        for (int k = 0; k < seg && left > 0; k++) begin
          if ($urandom_range(0, 99) < 3) hold_off(0);
          act = ($urandom_range(0, 99) < 45) ? ACT_LOAD : ACT_QUERY;
          sl = ($urandom_range(0, 9) < 7) ? SLOT_W'($urandom_range(0, scan_n - 1))
                                          : SLOT_W'($urandom);
          x = pick_coord();
          y = pick_coord();
          z = pick_coord();
          if ($urandom_range(0, 99) < ((act == ACT_LOAD) ? 15 : 30)) begin
            src = $urandom_range(0, scan_n - 1);
            x = pt_x[src];
            y = pt_y[src];
            z = pt_z[src];
          end
          send_beat(act, sl, x, y, z, 24'($urandom), 0, none);
          left--;
        end
      end
    end

    hold_off(scan_n + 16);
    if (errors == 0 && pending_hits.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
sv/nplk_pkg.sv
sv/nplk_ram.sv
sv/nplk_ctrl.sv
sv/nplk_dpath.sv
sv/nearest_point_label_lookup_core.sv
test/tb.sv
